@@ rtl/cna_pkg.sv @@
// Shared types, constants and helpers for the complex-number ALU.
`default_nettype none
package cna_pkg;

  // Fractional bits of the operand and result format.
  localparam int FRAC_BITS = 16;
  // Quotient bits that the divider develops; bigger quotients saturate anyway.
  localparam int QBITS = 35;
  // Rounding constant, half an LSB of the scaled product.
  localparam logic [63:0] HALF = (64'd1 << FRAC_BITS) >> 1;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_EQ  = 3'd4,
    OP_NE  = 3'd5
  } cna_op_t;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } cna_clamp_t;

  // One divider lane: sign, early overflow, partial remainder, numerator
  // bits still to shift in, quotient so far.
  typedef struct packed {
    logic             neg;
    logic             big;
    logic [63:0]      rem;
    logic [QBITS-1:0] nlo;
    logic [QBITS-1:0] quo;
  } cna_lane_t;

  // Payload that rides down the divider chain.
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] res_re;
    logic [31:0] res_im;
    logic        sat;
    logic        cmp;
    logic        dz;
    logic [63:0] den;
    cna_lane_t   re;
    cna_lane_t   im;
  } cna_pipe_t;

  // Sign-magnitude value to signed 32 bits with saturation.
  function automatic cna_clamp_t clamp(input logic neg, input logic [64:0] mag);
    cna_clamp_t c;
    logic [64:0] nm;
    nm = -mag;
    c.sat = 1'b0;
    if (neg) begin
      if (mag > 65'h0_8000_0000) begin
        c.val = 32'h8000_0000;
        c.sat = 1'b1;
      end else begin
        c.val = nm[31:0];
      end
    end else begin
      if (mag > 65'h0_7FFF_FFFF) begin
        c.val = 32'h7FFF_FFFF;
        c.sat = 1'b1;
      end else begin
        c.val = mag[31:0];
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/cna_front.sv @@
// Front pipeline: operand capture, products, sums, add/sub/mul results, divider setup.
`default_nettype none
module cna_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire  [2:0]          op,
  input  wire  signed [31:0]  ar,
  input  wire  signed [31:0]  ai,
  input  wire  signed [31:0]  br,
  input  wire  signed [31:0]  bi,
  output logic                out_valid,
  output cna_pkg::cna_pipe_t  out_pipe
);

  // stage 1: operands
  logic               v1_r;
  logic [2:0]         op1_r;
  logic signed [31:0] ar1_r, ai1_r, br1_r, bi1_r;

  // stage 2: products, add/sub sums, flags
  logic               v2_r;
  logic [2:0]         op2_r;
  logic signed [63:0] prr_r, pii_r, pir_r, pri_r, drr_r, dii_r;
  logic signed [32:0] asre2_r, asim2_r;
  logic               eq2_r, dz2_r;
  logic signed [63:0] prr_nxt, pii_nxt, pir_nxt, pri_nxt, drr_nxt, dii_nxt;
  logic signed [32:0] asre_nxt, asim_nxt;

  // stage 3: product sums, denominator
  logic               v3_r;
  logic [2:0]         op3_r;
  logic signed [64:0] sre3_r, sim3_r;
  logic [63:0]        den3_r;
  logic signed [32:0] asre3_r, asim3_r;
  logic               eq3_r, dz3_r;
  logic signed [64:0] sre_nxt, sim_nxt;

  // stage 4 outputs
  logic               v4_r;
  cna_pkg::cna_pipe_t pipe4_r, pipe_nxt;

  always_comb begin
    prr_nxt = ar1_r * br1_r;
    pii_nxt = ai1_r * bi1_r;
    pir_nxt = ai1_r * br1_r;
    pri_nxt = ar1_r * bi1_r;
    drr_nxt = br1_r * br1_r;
    dii_nxt = bi1_r * bi1_r;
    if (op1_r == cna_pkg::OP_SUB) begin
      asre_nxt = 33'(ar1_r) - 33'(br1_r);
      asim_nxt = 33'(ai1_r) - 33'(bi1_r);
    end else begin
      asre_nxt = 33'(ar1_r) + 33'(br1_r);
      asim_nxt = 33'(ai1_r) + 33'(bi1_r);
    end
  end

  always_comb begin
    if (op2_r == cna_pkg::OP_MUL) begin
      sre_nxt = 65'(prr_r) - 65'(pii_r);
      sim_nxt = 65'(pir_r) + 65'(pri_r);
    end else begin
      sre_nxt = 65'(prr_r) + 65'(pii_r);
      sim_nxt = 65'(pir_r) - 65'(pri_r);
    end
  end

  // stage 4: sign-magnitude, rounding and clamping, divider lane setup
  always_comb begin
    logic              nre, nim;
    logic [64:0]       nsre, nsim;
    logic [63:0]       mre, mim;
    logic [63:0]       rre, rim;
    logic [64:0]       sre_m, sim_m;
    logic [32:0]       aare, aaim;
    cna_pkg::cna_clamp_t cre, cim;
    nre   = sre3_r[64];
    nim   = sim3_r[64];
    nsre  = -sre3_r;
    nsim  = -sim3_r;
    mre   = nre ? nsre[63:0] : sre3_r[63:0];
    mim   = nim ? nsim[63:0] : sim3_r[63:0];
    rre   = mre >> (cna_pkg::QBITS - cna_pkg::FRAC_BITS);
    rim   = mim >> (cna_pkg::QBITS - cna_pkg::FRAC_BITS);
    sre_m = (65'(mre) + 65'(cna_pkg::HALF)) >> cna_pkg::FRAC_BITS;
    sim_m = (65'(mim) + 65'(cna_pkg::HALF)) >> cna_pkg::FRAC_BITS;
    aare  = asre3_r[32] ? -asre3_r : asre3_r;
    aaim  = asim3_r[32] ? -asim3_r : asim3_r;
    cre   = '0;
    cim   = '0;

    pipe_nxt        = '0;
    pipe_nxt.op     = op3_r;
    pipe_nxt.den    = den3_r;
    pipe_nxt.re.neg = nre;
    pipe_nxt.im.neg = nim;
    pipe_nxt.re.rem = rre;
    pipe_nxt.im.rem = rim;
    pipe_nxt.re.big = (rre >= den3_r);
    pipe_nxt.im.big = (rim >= den3_r);
    pipe_nxt.re.nlo = cna_pkg::QBITS'(mre << cna_pkg::FRAC_BITS);
    pipe_nxt.im.nlo = cna_pkg::QBITS'(mim << cna_pkg::FRAC_BITS);

    case (op3_r)
      cna_pkg::OP_ADD, cna_pkg::OP_SUB: begin
        cre = cna_pkg::clamp(asre3_r[32], 65'(aare));
        cim = cna_pkg::clamp(asim3_r[32], 65'(aaim));
      end
      cna_pkg::OP_MUL: begin
        cre = cna_pkg::clamp(nre && (sre_m != '0), sre_m);
        cim = cna_pkg::clamp(nim && (sim_m != '0), sim_m);
      end
      cna_pkg::OP_DIV: begin
        pipe_nxt.dz = dz3_r;
      end
      cna_pkg::OP_EQ: begin
        pipe_nxt.cmp = eq3_r;
      end
      cna_pkg::OP_NE: begin
        pipe_nxt.cmp = !eq3_r;
      end
      default: begin
      end
    endcase
    pipe_nxt.res_re = cre.val;
    pipe_nxt.res_im = cim.val;
    pipe_nxt.sat    = cre.sat | cim.sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
    op1_r   <= op;
    ar1_r   <= ar;
    ai1_r   <= ai;
    br1_r   <= br;
    bi1_r   <= bi;
    op2_r   <= op1_r;
    prr_r   <= prr_nxt;
    pii_r   <= pii_nxt;
    pir_r   <= pir_nxt;
    pri_r   <= pri_nxt;
    drr_r   <= drr_nxt;
    dii_r   <= dii_nxt;
    asre2_r <= asre_nxt;
    asim2_r <= asim_nxt;
    eq2_r   <= (ar1_r == br1_r) && (ai1_r == bi1_r);
    dz2_r   <= (br1_r == '0) && (bi1_r == '0);
    op3_r   <= op2_r;
    sre3_r  <= sre_nxt;
    sim3_r  <= sim_nxt;
    den3_r  <= drr_r + dii_r;
    asre3_r <= asre2_r;
    asim3_r <= asim2_r;
    eq3_r   <= eq2_r;
    dz3_r   <= dz2_r;
    pipe4_r <= pipe_nxt;
  end

  assign out_valid = v4_r;
  assign out_pipe  = pipe4_r;

endmodule
`default_nettype wire

@@ rtl/cna_div_step.sv @@
// One registered restoring-division step for both quotient lanes.
`default_nettype none
module cna_div_step (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire cna_pkg::cna_pipe_t in_pipe,
  output logic                out_valid,
  output cna_pkg::cna_pipe_t  out_pipe
);

  logic               v_r;
  cna_pkg::cna_pipe_t pipe_r, pipe_nxt;

  function automatic cna_pkg::cna_lane_t step(input cna_pkg::cna_lane_t l,
                                              input logic [63:0] den);
    cna_pkg::cna_lane_t o;
    logic [64:0] sh, df;
    logic        ge;
    o  = l;
    sh = {l.rem, l.nlo[cna_pkg::QBITS-1]};
    ge = (sh >= {1'b0, den});
    df = sh - {1'b0, den};
    o.rem = ge ? df[63:0] : sh[63:0];
    o.quo = {l.quo[cna_pkg::QBITS-2:0], ge};
    o.nlo = {l.nlo[cna_pkg::QBITS-2:0], 1'b0};
    return o;
  endfunction

  always_comb begin
    pipe_nxt    = in_pipe;
    pipe_nxt.re = step(in_pipe.re, in_pipe.den);
    pipe_nxt.im = step(in_pipe.im, in_pipe.den);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= in_valid;
    end
    pipe_r <= pipe_nxt;
  end

  assign out_valid = v_r;
  assign out_pipe  = pipe_r;

endmodule
`default_nettype wire

@@ rtl/complex_number_alu_core.sv @@
// Top level of the pipelined complex-number ALU.
// Usage:
//  - Input beat: drive in_opcode and the four Q16.16 operand parts, raise
//    start. A beat is taken at every edge with start high and busy low;
//    busy is always low, so a new beat can enter every cycle.
//  - Opcodes: add, subtract, multiply, divide, equal, not equal; the two
//    unused codes give an all-zero result.
//  - Result beat: out_strobe is high for exactly one cycle with the result
//    parts and the compare, divide-by-zero and saturation flags. The
//    receiver cannot hold results off, and none is needed: the pipeline
//    never stalls.
//  - Stages: every opcode takes the same path through 4 front stages, 35
//    divider steps and 1 output stage.
//  - Throughput: one beat per cycle; the divider develops one quotient
//    bit per stage over 35 stages.
//  - Results leave in input order.
//  - Reset (rst_n low, synchronous) clears every stage valid bit; beats in
//    flight are dropped and no strobe follows.
`default_nettype none
module complex_number_alu_core (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire  [2:0]         in_opcode,
  input  wire  signed [31:0] in_a_re,
  input  wire  signed [31:0] in_a_im,
  input  wire  signed [31:0] in_b_re,
  input  wire  signed [31:0] in_b_im,
  output logic               out_strobe,
  output logic signed [31:0] out_res_re,
  output logic signed [31:0] out_res_im,
  output logic               out_compare_true,
  output logic               out_div_zero,
  output logic               out_saturated
);

  // Stage valid bits and payloads along the divider chain.
  logic               vc [0:cna_pkg::QBITS];
  cna_pkg::cna_pipe_t pc [0:cna_pkg::QBITS];

  // Output register.
  logic        strobe_r;
  logic [31:0] re_r, im_r, re_nxt, im_nxt;
  logic        cmp_r, dz_r, sat_r, cmp_nxt, dz_nxt, sat_nxt;

  // No back pressure anywhere: the pipeline always advances.
  assign busy = 1'b0;

  cna_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .op        (in_opcode),
    .ar        (in_a_re),
    .ai        (in_a_im),
    .br        (in_b_re),
    .bi        (in_b_im),
    .out_valid (vc[0]),
    .out_pipe  (pc[0])
  );

  // Divider chain: one quotient bit per stage for both parts.
  for (genvar g = 0; g < cna_pkg::QBITS; g++) begin : g_div
    cna_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vc[g]),
      .in_pipe   (pc[g]),
      .out_valid (vc[g+1]),
      .out_pipe  (pc[g+1])
    );
  end

  // Quotient rounding (half away from zero) and clamping.
  function automatic cna_pkg::cna_clamp_t finish(input cna_pkg::cna_lane_t l,
                                                 input logic [63:0] den);
    cna_pkg::cna_clamp_t c;
    logic [cna_pkg::QBITS:0] qr;
    logic                    up;
    up = ({l.rem, 1'b0} >= {1'b0, den});
    qr = {1'b0, l.quo} + (cna_pkg::QBITS+1)'(up);
    if (l.big) begin
      // quotient far beyond range: saturate toward the sign
      c.val = l.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      c.sat = 1'b1;
    end else begin
      c = cna_pkg::clamp(l.neg && (qr != '0), 65'(qr));
    end
    return c;
  endfunction

  always_comb begin
    cna_pkg::cna_pipe_t  p;
    cna_pkg::cna_clamp_t cre, cim;
    p       = pc[cna_pkg::QBITS];
    cre     = finish(p.re, p.den);
    cim     = finish(p.im, p.den);
    re_nxt  = p.res_re;
    im_nxt  = p.res_im;
    sat_nxt = p.sat;
    cmp_nxt = p.cmp;
    dz_nxt  = p.dz;
    if (p.op == cna_pkg::OP_DIV) begin
      if (p.dz) begin
        // zero divisor: zero result, flag only
        re_nxt  = '0;
        im_nxt  = '0;
        sat_nxt = 1'b0;
      end else begin
        re_nxt  = cre.val;
        im_nxt  = cim.val;
        sat_nxt = cre.sat | cim.sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= vc[cna_pkg::QBITS];
    end
    re_r  <= re_nxt;
    im_r  <= im_nxt;
    cmp_r <= cmp_nxt;
    dz_r  <= dz_nxt;
    sat_r <= sat_nxt;
  end

  assign out_strobe       = strobe_r;
  assign out_res_re       = re_r;
  assign out_res_im       = im_r;
  assign out_compare_true = cmp_r;
  assign out_div_zero     = dz_r;
  assign out_saturated    = sat_r;

endmodule
`default_nettype wire
